// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions with the block reset as disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define HFTQ_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define HFTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== sv/hftq_pkg.sv =====
// ----------------------------------------------------------------------------
// hftq_pkg
// Types and constants shared by the height field query block.
// ----------------------------------------------------------------------------
package hftq_pkg;

	localparam int MAX_COLS = 128;
	localparam int MAX_ROWS = 128;
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int BANK_AW  = (COL_W - 1) + (ROW_W - 1);
	localparam int BANK_DEPTH = 1 << BANK_AW;

	// front divider: (pos << 16) / cell_size, nonnegative positions only
	localparam int NUM_W     = 47;
	localparam int DIV_STEPS = NUM_W;

	// back arithmetic widths
	localparam int FR_W     = 17;
	localparam int DIFF_W   = 33;
	localparam int PROD_W   = 51;
	localparam int ACC_W    = 52;
	localparam int WIN_W    = 63;
	localparam int NRM_W    = 30;
	localparam int SQ_W     = 60;
	localparam int SUM_W    = 62;
	localparam int ROOT_W   = 31;
	localparam int SQ_STEPS = SUM_W / 2;
	localparam int QN_W     = 15;
	localparam int ND_NUM_W = NRM_W + QN_W;

	localparam logic [FR_W-1:0] FRAC_ONE = FR_W'(65536);

	// middle queue
	localparam int Q_DEPTH = 16;
	localparam int Q_PW    = $clog2(Q_DEPTH);

	// config register indexes
	localparam logic [1:0] CFG_COLS = 2'd0;
	localparam logic [1:0] CFG_ROWS = 2'd1;
	localparam logic [1:0] CFG_CELL = 2'd2;
	localparam logic [1:0] CFG_MODE = 2'd3;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_QUERY = 1'b1
	} hftq_act_t;

	typedef struct packed {
		logic [7:0]  cols;
		logic [7:0]  rows;
		logic [30:0] cs;
		logic        mode;
	} hftq_cfg_t;

	typedef struct packed {
		logic             action;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [FR_W-1:0]  t;
		logic [FR_W-1:0]  u;
		logic [31:0]      data;
	} hftq_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} hftq_qstat_t;

	typedef struct packed {
		logic [31:0]            height;
		logic [2:0]             neg;
		logic [2:0][NRM_W-1:0]  n;
	} hftq_side_t;

endpackage

// ===== sv/hftq_front.sv =====
// ----------------------------------------------------------------------------
// hftq_front
// Accepts requests, finds the grid cell and fractions of a query with a
// pipelined restoring divider, clamps to the grid and pushes to the queue.
// ----------------------------------------------------------------------------
module hftq_front import hftq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  hftq_cfg_t        cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             action,
	input  logic [6:0]       write_col,
	input  logic [6:0]       write_row,
	input  logic signed [31:0] sample_height,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  hftq_qstat_t      qstat,
	output logic             push,
	output hftq_item_t       push_item
);

	typedef struct packed {
		logic             action;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [31:0]      data;
		logic             negx;
		logic             negy;
		logic [30:0]      remx;
		logic [30:0]      remy;
		logic [NUM_W-1:0] dx;
		logic [NUM_W-1:0] dy;
	} fdiv_t;

	logic       en;
	logic       fdiv_v_s [0:DIV_STEPS];
	fdiv_t      fdiv_s   [0:DIV_STEPS];
	logic       loc_v_s2;
	hftq_item_t loc_s2;
	fdiv_t      load;
	hftq_item_t loc_next;
	logic [7:0] col_lim;
	logic [7:0] row_lim;

	// one quotient bit per stage for both axes
	function automatic fdiv_t fdiv_step(fdiv_t s, logic [30:0] d);
		fdiv_t      o;
		logic [31:0] rx;
		logic [31:0] ry;
		o  = s;
		rx = {s.remx, s.dx[NUM_W-1]};
		ry = {s.remy, s.dy[NUM_W-1]};
		if (rx >= {1'b0, d}) begin
			o.remx = 31'(rx - {1'b0, d});
			o.dx   = {s.dx[NUM_W-2:0], 1'b1};
		end else begin
			o.remx = rx[30:0];
			o.dx   = {s.dx[NUM_W-2:0], 1'b0};
		end
		if (ry >= {1'b0, d}) begin
			o.remy = 31'(ry - {1'b0, d});
			o.dy   = {s.dy[NUM_W-2:0], 1'b1};
		end else begin
			o.remy = ry[30:0];
			o.dy   = {s.dy[NUM_W-2:0], 1'b0};
		end
		return o;
	endfunction

	// pipeline advances unless the finished request cannot enter the queue
	assign en        = !(loc_v_s2 && qstat.full);
	assign in_ready  = en;
	assign push      = loc_v_s2 && !qstat.full;
	assign push_item = loc_s2;

	// stage zero load; negative positions clamp to zero, no divide needed
	always_comb begin
		load        = '0;
		load.action = action;
		load.col    = write_col;
		load.row    = write_row;
		load.data   = sample_height;
		load.negx   = pos_x[31];
		load.negy   = pos_y[31];
		load.dx     = pos_x[31] ? '0 : {pos_x[30:0], 16'b0};
		load.dy     = pos_y[31] ? '0 : {pos_y[30:0], 16'b0};
	end

	// clamp quotient to the grid
	assign col_lim = cfg.cols - 8'd2;
	assign row_lim = cfg.rows - 8'd2;

	always_comb begin
		loc_next        = '0;
		loc_next.action = fdiv_s[DIV_STEPS].action;
		loc_next.data   = fdiv_s[DIV_STEPS].data;
		if (fdiv_s[DIV_STEPS].action == ACT_WRITE) begin
			loc_next.col = fdiv_s[DIV_STEPS].col;
			loc_next.row = fdiv_s[DIV_STEPS].row;
		end else begin
			if (fdiv_s[DIV_STEPS].negx) begin
				loc_next.col = '0;
				loc_next.t   = '0;
			end else if (fdiv_s[DIV_STEPS].dx[NUM_W-1:16] > {23'b0, col_lim}) begin
				loc_next.col = col_lim[COL_W-1:0];
				loc_next.t   = FRAC_ONE;
			end else begin
				loc_next.col = fdiv_s[DIV_STEPS].dx[16 +: COL_W];
				loc_next.t   = {1'b0, fdiv_s[DIV_STEPS].dx[15:0]};
			end
			if (fdiv_s[DIV_STEPS].negy) begin
				loc_next.row = '0;
				loc_next.u   = '0;
			end else if (fdiv_s[DIV_STEPS].dy[NUM_W-1:16] > {23'b0, row_lim}) begin
				loc_next.row = row_lim[ROW_W-1:0];
				loc_next.u   = FRAC_ONE;
			end else begin
				loc_next.row = fdiv_s[DIV_STEPS].dy[16 +: ROW_W];
				loc_next.u   = {1'b0, fdiv_s[DIV_STEPS].dy[15:0]};
			end
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DIV_STEPS; i++) fdiv_v_s[i] <= 1'b0;
			loc_v_s2 <= 1'b0;
		end else if (en) begin
			fdiv_v_s[0] <= in_valid;
			for (int i = 0; i < DIV_STEPS; i++) fdiv_v_s[i+1] <= fdiv_v_s[i];
			loc_v_s2 <= fdiv_v_s[DIV_STEPS];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			fdiv_s[0] <= load;
			for (int i = 0; i < DIV_STEPS; i++) fdiv_s[i+1] <= fdiv_step(fdiv_s[i], cfg.cs);
			loc_s2 <= loc_next;
		end
	end

endmodule

// ===== sv/hftq_queue.sv =====
// ----------------------------------------------------------------------------
// hftq_queue
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module hftq_queue import hftq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  hftq_item_t  push_item,
	input  logic        pop,
	output hftq_item_t  head,
	output hftq_qstat_t qstat
);

	hftq_item_t        slot_q [0:Q_DEPTH-1];
	logic [Q_PW-1:0]   wr_ptr_q;
	logic [Q_PW-1:0]   rd_ptr_q;
	logic [Q_PW:0]     count_q;

	assign head        = slot_q[rd_ptr_q];
	assign qstat.full  = (count_q == (Q_PW+1)'(Q_DEPTH));
	assign qstat.empty = (count_q == '0);

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (!push && pop) count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_item;
	end

endmodule

// ===== sv/hftq_back.sv =====
// ----------------------------------------------------------------------------
// hftq_back
// Holds the height grid in four banks, interpolates the height and computes
// the unit normal with a pipelined square root and divide.
// ----------------------------------------------------------------------------
module hftq_back import hftq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  hftq_cfg_t          cfg,
	input  hftq_qstat_t        qstat,
	input  hftq_item_t         head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] surface_height,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z
);

	typedef struct packed {
		logic [32:0]       rem;
		logic [ROOT_W-1:0] root;
		logic [SUM_W-1:0]  rad;
		hftq_side_t        side;
	} sq_t;

	typedef struct packed {
		logic [2:0][ROOT_W-1:0] rem;
		logic [2:0][QN_W-1:0]   dd;
		logic [ROOT_W-1:0]      len;
		hftq_side_t             side;
	} nd_t;

	logic en;
	logic take;
	logic is_write;

	// stage 1: bank read
	logic                  v_s1;
	logic                  ix0_s1, iy0_s1;
	logic [FR_W-1:0]       t_s1, u_s1;
	logic [31:0]           bank_rd_s1 [0:3];

	// stage 2: triangle select
	logic                      v_s2;
	logic [FR_W-1:0]           t_s2, u_s2;
	logic signed [DIFF_W-1:0]  da_s2, db_s2, v0_s2, v1_s2;
	logic signed [31:0]        h00_s2;

	// stage 3: products and magnitudes
	logic                      v_s3;
	logic signed [PROD_W-1:0]  p1_s3, p2_s3;
	logic signed [31:0]        h00_s3;
	logic [2:0][DIFF_W-1:0]    m_s3;
	logic [2:0]                neg_s3;

	// stage 4 to 6: height and normalization window
	logic                      v_s4, v_s5, v_s6;
	logic [31:0]               h_s4, h_s5, h_s6;
	logic [2:0]                neg_s4, neg_s5, neg_s6;
	logic [2:0][WIN_W-1:0]     w_s4, w_s5;
	logic [WIN_W-1:0]          or_s4, or_s5;
	logic [2:0][NRM_W-1:0]     n_s6;

	// stage 7: squares
	logic                      v_s7;
	logic [2:0][SQ_W-1:0]      sq_s7;
	hftq_side_t                side_s7;

	// square root and divide stages
	logic   sq_v_s [0:SQ_STEPS];
	sq_t    sq_s   [0:SQ_STEPS];
	logic   nd_v_s [0:QN_W];
	nd_t    nd_s   [0:QN_W];
	logic   out_v_q;

	// combinational helpers
	logic signed [31:0]        h00_c, h10_c, h01_c, h11_c;
	logic signed [DIFF_W-1:0]  da_c, db_c, v0_c, v1_c;
	logic signed [33:0]        a0_c, a1_c;
	logic signed [ACC_W-1:0]   acc_c;
	logic signed [35:0]        hs_c;
	logic [31:0]               hsat_c;
	logic [2:0][WIN_W-1:0]     w5_c, w6_c;
	logic [WIN_W-1:0]          o5_c, o6_c;
	sq_t                       sq_load;
	nd_t                       nd_load;
	logic [15:0]               nrm_c [0:2];

	assign en       = !out_v_q || out_ready;
	assign take     = en && !qstat.empty;
	assign pop      = take;
	assign is_write = (head.action == ACT_WRITE);

	// grid banks by column and row parity
	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [31:0]        mem [0:BANK_DEPTH-1];
		logic [COL_W-1:0]   rc;
		logic [ROW_W-1:0]   rr;
		logic [BANK_AW-1:0] raddr;
		logic [BANK_AW-1:0] waddr;
		logic               we;

		assign rc    = (head.col[0] == 1'(b % 2)) ? head.col : head.col + 1'b1;
		assign rr    = (head.row[0] == 1'(b / 2)) ? head.row : head.row + 1'b1;
		assign raddr = {rr[ROW_W-1:1], rc[COL_W-1:1]};
		assign waddr = {head.row[ROW_W-1:1], head.col[COL_W-1:1]};
		assign we    = take && is_write && (head.col[0] == 1'(b % 2))
			&& (head.row[0] == 1'(b / 2));

		always_ff @(posedge clk) begin
			if (we) mem[waddr] <= head.data;
			if (en) bank_rd_s1[b] <= mem[raddr];
		end
	end

	// corner pick and triangle edges; da goes with t, db with u
	always_comb begin
		h00_c = bank_rd_s1[{iy0_s1, ix0_s1}];
		h10_c = bank_rd_s1[{iy0_s1, !ix0_s1}];
		h01_c = bank_rd_s1[{!iy0_s1, ix0_s1}];
		h11_c = bank_rd_s1[{!iy0_s1, !ix0_s1}];
		if (t_s1 > u_s1) begin
			da_c = DIFF_W'(h10_c) - DIFF_W'(h00_c);
			db_c = DIFF_W'(h11_c) - DIFF_W'(h10_c);
			v0_c = DIFF_W'(h00_c) - DIFF_W'(h10_c);
			v1_c = DIFF_W'(h10_c) - DIFF_W'(h11_c);
		end else begin
			da_c = DIFF_W'(h11_c) - DIFF_W'(h01_c);
			db_c = DIFF_W'(h01_c) - DIFF_W'(h00_c);
			v0_c = DIFF_W'(h01_c) - DIFF_W'(h11_c);
			v1_c = DIFF_W'(h00_c) - DIFF_W'(h01_c);
		end
	end

	// orientation and magnitudes
	always_comb begin
		a0_c = cfg.mode ? -34'(v0_s2) : 34'(v0_s2);
		a1_c = cfg.mode ? -34'(v1_s2) : 34'(v1_s2);
	end

	// height rounding and saturation
	always_comb begin
		acc_c = ACC_W'(p1_s3) + ACC_W'(p2_s3) + ACC_W'(32768);
		hs_c  = 36'(acc_c[ACC_W-1:16]) + 36'(h00_s3);
		if (hs_c > 36'sd2147483647)       hsat_c = 32'h7FFF_FFFF;
		else if (hs_c < -36'sd2147483648) hsat_c = 32'h8000_0000;
		else                              hsat_c = hs_c[31:0];
	end

	// leading-one alignment, coarse steps
	always_comb begin
		w5_c = w_s4;
		o5_c = or_s4;
		if (o5_c[WIN_W-1 -: 32] == '0) begin
			o5_c = o5_c << 32;
			for (int k = 0; k < 3; k++) w5_c[k] = w5_c[k] << 32;
		end
		if (o5_c[WIN_W-1 -: 16] == '0) begin
			o5_c = o5_c << 16;
			for (int k = 0; k < 3; k++) w5_c[k] = w5_c[k] << 16;
		end
		if (o5_c[WIN_W-1 -: 8] == '0) begin
			o5_c = o5_c << 8;
			for (int k = 0; k < 3; k++) w5_c[k] = w5_c[k] << 8;
		end
	end

	// leading-one alignment, fine steps
	always_comb begin
		w6_c = w_s5;
		o6_c = or_s5;
		if (o6_c[WIN_W-1 -: 4] == '0) begin
			o6_c = o6_c << 4;
			for (int k = 0; k < 3; k++) w6_c[k] = w6_c[k] << 4;
		end
		if (o6_c[WIN_W-1 -: 2] == '0) begin
			o6_c = o6_c << 2;
			for (int k = 0; k < 3; k++) w6_c[k] = w6_c[k] << 2;
		end
		if (!o6_c[WIN_W-1]) begin
			for (int k = 0; k < 3; k++) w6_c[k] = w6_c[k] << 1;
		end
	end

	// sqrt load
	always_comb begin
		sq_load      = '0;
		sq_load.rad  = SUM_W'(sq_s7[0]) + SUM_W'(sq_s7[1]) + SUM_W'(sq_s7[2]);
		sq_load.side = side_s7;
	end

	// divide load: numerator n * 16384 + len / 2, top bits start the remainder
	always_comb begin
		logic [ND_NUM_W-1:0] num;
		nd_load      = '0;
		nd_load.len  = sq_s[SQ_STEPS].root;
		nd_load.side = sq_s[SQ_STEPS].side;
		for (int k = 0; k < 3; k++) begin
			num = {sq_s[SQ_STEPS].side.n[k], 14'b0}
				+ ND_NUM_W'(sq_s[SQ_STEPS].root >> 1);
			nd_load.rem[k] = ROOT_W'(num[ND_NUM_W-1:QN_W]);
			nd_load.dd[k]  = num[QN_W-1:0];
		end
	end

	// signed normal components
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nrm_c[k] = nd_s[QN_W].side.neg[k] ? -16'(nd_s[QN_W].dd[k])
				: 16'(nd_s[QN_W].dd[k]);
		end
	end

	// one root bit per stage
	function automatic sq_t sq_step(sq_t s);
		sq_t         o;
		logic [34:0] r;
		logic [34:0] tr;
		o  = s;
		r  = {s.rem, s.rad[SUM_W-1 -: 2]};
		tr = {2'b0, s.root, 2'b01};
		o.rad = s.rad << 2;
		if (r >= tr) begin
			o.rem  = 33'(r - tr);
			o.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			o.rem  = r[32:0];
			o.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return o;
	endfunction

	// one quotient bit per stage for all three components
	function automatic nd_t nd_step(nd_t s);
		nd_t         o;
		logic [31:0] r;
		o = s;
		for (int k = 0; k < 3; k++) begin
			r = {s.rem[k], s.dd[k][QN_W-1]};
			if (r >= {1'b0, s.len}) begin
				o.rem[k] = ROOT_W'(r - {1'b0, s.len});
				o.dd[k]  = {s.dd[k][QN_W-2:0], 1'b1};
			end else begin
				o.rem[k] = r[ROOT_W-1:0];
				o.dd[k]  = {s.dd[k][QN_W-2:0], 1'b0};
			end
		end
		return o;
	endfunction

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
			for (int i = 0; i <= SQ_STEPS; i++) sq_v_s[i] <= 1'b0;
			for (int i = 0; i <= QN_W; i++) nd_v_s[i] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1 <= take && !is_write;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			sq_v_s[0] <= v_s7;
			for (int i = 0; i < SQ_STEPS; i++) sq_v_s[i+1] <= sq_v_s[i];
			nd_v_s[0] <= sq_v_s[SQ_STEPS];
			for (int i = 0; i < QN_W; i++) nd_v_s[i+1] <= nd_v_s[i];
			out_v_q <= nd_v_s[QN_W];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			ix0_s1 <= head.col[0];
			iy0_s1 <= head.row[0];
			t_s1   <= head.t;
			u_s1   <= head.u;

			t_s2   <= t_s1;
			u_s2   <= u_s1;
			da_s2  <= da_c;
			db_s2  <= db_c;
			v0_s2  <= v0_c;
			v1_s2  <= v1_c;
			h00_s2 <= h00_c;

			p1_s3  <= PROD_W'($signed({1'b0, t_s2}) * da_s2);
			p2_s3  <= PROD_W'($signed({1'b0, u_s2}) * db_s2);
			h00_s3 <= h00_s2;
			m_s3[0]   <= a0_c[33] ? DIFF_W'(-a0_c) : a0_c[DIFF_W-1:0];
			m_s3[1]   <= a1_c[33] ? DIFF_W'(-a1_c) : a1_c[DIFF_W-1:0];
			m_s3[2]   <= {2'b0, cfg.cs};
			neg_s3[0] <= a0_c[33];
			neg_s3[1] <= a1_c[33];
			neg_s3[2] <= cfg.mode;

			h_s4   <= hsat_c;
			neg_s4 <= neg_s3;
			for (int k = 0; k < 3; k++) w_s4[k] <= {m_s3[k], 30'b0};
			or_s4  <= {(m_s3[0] | m_s3[1] | m_s3[2]), 30'b0};

			h_s5   <= h_s4;
			neg_s5 <= neg_s4;
			w_s5   <= w5_c;
			or_s5  <= o5_c;

			h_s6   <= h_s5;
			neg_s6 <= neg_s5;
			for (int k = 0; k < 3; k++) n_s6[k] <= w6_c[k][WIN_W-1 -: NRM_W];

			for (int k = 0; k < 3; k++) sq_s7[k] <= n_s6[k] * n_s6[k];
			side_s7.height <= h_s6;
			side_s7.neg    <= neg_s6;
			side_s7.n      <= n_s6;

			sq_s[0] <= sq_load;
			for (int i = 0; i < SQ_STEPS; i++) sq_s[i+1] <= sq_step(sq_s[i]);

			nd_s[0] <= nd_load;
			for (int i = 0; i < QN_W; i++) nd_s[i+1] <= nd_step(nd_s[i]);

			surface_height <= nd_s[QN_W].side.height;
			normal_x       <= nrm_c[0];
			normal_y       <= nrm_c[1];
			normal_z       <= nrm_c[2];
		end
	end

	assign out_valid = out_v_q;

endmodule

// ===== sv/heightfield_triangle_query_top.sv =====
// ----------------------------------------------------------------------------
// heightfield_triangle_query_top
// Height grid with triangle interpolation and unit surface normal.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | action, write_col, write_row,
//           |           |                      | sample_height, pos_x, pos_y
//   out     | output    | out_valid/out_ready  | surface_height, normal_x/y/z
//   cfg     | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One request per cycle sustained while the output is ready and the queue has
// room. A query passes the front cell divider (one quotient bit a stage),
// the queue, then the back (grid read, interpolation, 31 root stages,
// 15 divide stages) before its result appears. Writes give no result and
// reach the grid in the back. The grid is not cleared by reset.
// A stalled output holds the back; the 16-entry queue keeps the front
// taking requests until it fills. Config writes are always ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module heightfield_triangle_query_top import hftq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic [6:0]         write_col,
	input  logic [6:0]         write_row,
	input  logic signed [31:0] sample_height,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] surface_height,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	logic [7:0]  grid_cols_q;
	logic [7:0]  grid_rows_q;
	logic [30:0] cell_size_q;
	logic        surface_mode_q;
	hftq_cfg_t   cfg;

	logic        q_push;
	logic        q_pop;
	hftq_item_t  q_push_item;
	hftq_item_t  q_head;
	hftq_qstat_t q_stat;

	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q    <= 8'd2;
			grid_rows_q    <= 8'd2;
			cell_size_q    <= 31'd65536;
			surface_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_COLS: grid_cols_q    <= cfg_data[7:0];
				CFG_ROWS: grid_rows_q    <= cfg_data[7:0];
				CFG_CELL: cell_size_q    <= cfg_data[30:0];
				CFG_MODE: surface_mode_q <= cfg_data[0];
				default:  ;
			endcase
		end
	end

	// effective settings: grid size clamped, zero spacing taken as one LSB
	always_comb begin
		if (grid_cols_q < 8'd2)                  cfg.cols = 8'd2;
		else if (grid_cols_q > 8'(MAX_COLS))     cfg.cols = 8'(MAX_COLS);
		else                                     cfg.cols = grid_cols_q;
		if (grid_rows_q < 8'd2)                  cfg.rows = 8'd2;
		else if (grid_rows_q > 8'(MAX_ROWS))     cfg.rows = 8'(MAX_ROWS);
		else                                     cfg.rows = grid_rows_q;
		cfg.cs   = (cell_size_q == '0) ? 31'd1 : cell_size_q;
		cfg.mode = surface_mode_q;
	end

	hftq_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.write_col     (write_col),
		.write_row     (write_row),
		.sample_height (sample_height),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.qstat         (q_stat),
		.push          (q_push),
		.push_item     (q_push_item)
	);

	hftq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.pop       (q_pop),
		.head      (q_head),
		.qstat     (q_stat)
	);

	hftq_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.qstat          (q_stat),
		.head           (q_head),
		.pop            (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.surface_height (surface_height),
		.normal_x       (normal_x),
		.normal_y       (normal_y),
		.normal_z       (normal_z)
	);

	// checks
	`HFTQ_ASSERT_IMPL(a_q_no_overflow, q_push && !q_pop, !q_stat.full, "queue overflow")
	`HFTQ_ASSERT_IMPL(a_q_no_underflow, q_pop, !q_stat.empty, "queue underflow")
	`HFTQ_ASSERT_IMPL(a_front_stall, !in_ready, q_stat.full, "front stalled with queue room")
	`HFTQ_ASSERT_NEXT(a_back_hold, out_valid && !out_ready, out_valid, "result dropped")

endmodule
